[rtl/core/rsgm_pkg.sv]
// Shared types and constants for the restriction site gap map.
`default_nettype none
package rsgm_pkg;

  localparam int unsigned SITE_W       = 64;
  localparam int unsigned SITE_LEN_W   = 4;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned POS_EXT_W    = 48;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_PTR_W  = 2;
  localparam int unsigned QUEUE_CNT_W  = 3;

  localparam logic [SITE_W-1:0]     SITE_RESET     = 64'h0000_0000_4754_4143;
  localparam logic [SITE_LEN_W-1:0] SITE_LEN_RESET = 4'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_SITE_CHARS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SITE_LENGTH = 2'd1;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] KIND_PREFIX  = 2'd0;
  localparam logic [1:0] KIND_GAP     = 2'd1;
  localparam logic [1:0] KIND_POSTFIX = 2'd2;
  localparam logic [1:0] KIND_NO_MAP  = 2'd3;

  typedef struct packed {
    logic               two;
    logic [1:0]         kind0;
    logic [VALUE_W-1:0] value0;
    logic [1:0]         kind1;
    logic [VALUE_W-1:0] value1;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   empty;
    logic   full;
    entry_t head;
  } queue_stat_t;

endpackage
`default_nettype wire

[rtl/core/rsgm_front.sv]
// Front end: window, site compare, position tracking and result building.
`default_nettype none
module rsgm_front #(
  parameter int unsigned MAX_SITE  = 8,
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic                           command,
  input  wire logic [7:0]                     base_char,
  input  wire logic [rsgm_pkg::SITE_W-1:0]    site_chars,
  input  wire logic [rsgm_pkg::SITE_LEN_W-1:0] site_length,
  output rsgm_pkg::push_t                     push_out
);

  localparam int unsigned LEN_W = $clog2(MAX_SITE + 1);
  localparam int unsigned IDX_W = (MAX_SITE > 1) ? $clog2(MAX_SITE) : 1;
  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  logic [7:0]           window [MAX_SITE];
  logic [7:0]           win_next [MAX_SITE];
  logic [POS_WIDTH-1:0] position;
  logic [POS_WIDTH-1:0] last_start;
  logic [1:0]           match_count;

  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     half;
  logic [IDX_W-1:0]     len_idx;
  logic [POS_WIDTH-1:0] pos_next;
  logic [POS_WIDTH-1:0] start;
  logic [MAX_SITE-1:0]  match_by_len;
  logic                 hit;
  logic [7:0]           up_char;

  function automatic logic [rsgm_pkg::VALUE_W-1:0] sat(input logic [POS_WIDTH-1:0] v);
    logic [rsgm_pkg::POS_EXT_W-1:0] w;
    w = rsgm_pkg::POS_EXT_W'(v);
    if (w[rsgm_pkg::POS_EXT_W-1:rsgm_pkg::VALUE_W] != '0) begin
      return '1;
    end
    return w[rsgm_pkg::VALUE_W-1:0];
  endfunction

  always_comb begin
    if (site_length == '0) begin
      len = LEN_W'(1);
    end else if (32'(site_length) > MAX_SITE) begin
      len = LEN_W'(MAX_SITE);
    end else begin
      len = LEN_W'(site_length);
    end
    half = len >> 1;
  end

  always_comb begin
    up_char = base_char;
    if (base_char inside {[8'h61:8'h7a]}) begin
      up_char = base_char - 8'd32;
    end
    for (int k = 0; k < MAX_SITE - 1; k++) begin
      win_next[k] = window[k + 1];
    end
    win_next[MAX_SITE-1] = up_char;
  end

  // one compare set per possible site length
  always_comb begin
    for (int l = 1; l <= MAX_SITE; l++) begin
      match_by_len[l-1] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (site_chars[8*j +: 8] != win_next[MAX_SITE - l + j]) begin
          match_by_len[l-1] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    len_idx  = IDX_W'(len - 1'b1);
    pos_next = (position == POS_MAX) ? position : position + 1'b1;
    start    = pos_next - POS_WIDTH'(len);
    hit      = (pos_next >= POS_WIDTH'(len)) && match_by_len[len_idx];
  end

  always_comb begin
    push_out = '0;
    if (accept) begin
      if (command == rsgm_pkg::CMD_END) begin
        if (match_count >= 2'd2) begin
          push_out.push         = 1'b1;
          push_out.entry.kind0  = rsgm_pkg::KIND_POSTFIX;
          push_out.entry.value0 = sat(position - last_start - POS_WIDTH'(half));
        end else if (position != '0) begin
          push_out.push        = 1'b1;
          push_out.entry.kind0 = rsgm_pkg::KIND_NO_MAP;
        end
      end else if (hit && match_count != 2'd0) begin
        push_out.push = 1'b1;
        if (match_count == 2'd1) begin
          push_out.entry.two    = 1'b1;
          push_out.entry.kind0  = rsgm_pkg::KIND_PREFIX;
          push_out.entry.value0 = sat(last_start + POS_WIDTH'(half));
          push_out.entry.kind1  = rsgm_pkg::KIND_GAP;
          push_out.entry.value1 = sat(start - last_start);
        end else begin
          push_out.entry.kind0  = rsgm_pkg::KIND_GAP;
          push_out.entry.value0 = sat(start - last_start);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_SITE; k++) window[k] <= '0;
      position    <= '0;
      last_start  <= '0;
      match_count <= '0;
    end else if (accept) begin
      if (command == rsgm_pkg::CMD_END) begin
        for (int k = 0; k < MAX_SITE; k++) window[k] <= '0;
        position    <= '0;
        last_start  <= '0;
        match_count <= '0;
      end else begin
        for (int k = 0; k < MAX_SITE; k++) window[k] <= win_next[k];
        position <= pos_next;
        if (hit) begin
          last_start  <= start;
          match_count <= (match_count == 2'd0) ? 2'd1 : 2'd2;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/rsgm_queue.sv]
// Short request queue between the front end and the result sequencer.
`default_nettype none
module rsgm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rsgm_pkg::push_t  push_in,
  input  wire logic             pop,
  output rsgm_pkg::queue_stat_t stat
);

  rsgm_pkg::entry_t                     mem [rsgm_pkg::QUEUE_DEPTH];
  logic [rsgm_pkg::QUEUE_PTR_W-1:0]     wr_ptr;
  logic [rsgm_pkg::QUEUE_PTR_W-1:0]     rd_ptr;
  logic [rsgm_pkg::QUEUE_CNT_W-1:0]     count;
  logic                                 do_push;
  logic                                 do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == rsgm_pkg::QUEUE_CNT_W'(rsgm_pkg::QUEUE_DEPTH));
  assign stat.head  = mem[rd_ptr];
  assign do_push    = push_in.push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_in.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/rsgm_back.sv]
// Back end: walks each queued request out as one or two results.
`default_nettype none
module rsgm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rsgm_pkg::queue_stat_t         stat,
  output logic                               pop,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic [1:0]                         kind,
  output logic [rsgm_pkg::VALUE_W-1:0]       value,
  output logic                               last_of_run
);

  logic sub;

  assign result_valid = !stat.empty;
  assign kind         = sub ? stat.head.kind1  : stat.head.kind0;
  assign value        = sub ? stat.head.value1 : stat.head.value0;
  assign last_of_run  = sub || !stat.head.two;
  assign pop          = result_valid && result_ready && last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (result_valid && result_ready) begin
      sub <= !last_of_run;
    end
  end

endmodule
`default_nettype wire

[rtl/core/restriction_site_gap_map.sv]
// Top level of the restriction site gap map.
//
// Items arrive on item_valid/item_ready: command 0 carries one sequence
// character in base_char, command 1 ends the record. Results leave on
// result_valid/result_ready as kind/value/last_of_run: a prefix and a gap on
// the second site match, a gap on each later match, and at the end of a
// non-empty record a postfix or a no-map marker. Site registers are written on
// cfg_valid/cfg_ready (index 0 site_chars, index 1 site_length), always
// ready; the user must write them only while the block is idle, as the block
// has no check for it. Throughput: one item per cycle while item_ready is high;
// the front end does the full window compare in the accept cycle. Results are
// registered in the request queue, and an item that gives two results holds
// its queue entry until both are taken. A four-entry request queue decouples
// the sides: when the receiver stalls the queue fills and item_ready drops
// only once it is full. Reset clears the window, position and match state,
// and loads site CATG with length 4; no clearing pass is needed.
`default_nettype none
module restriction_site_gap_map #(
  parameter int unsigned MAX_SITE  = 8,
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire logic                              command,
  input  wire logic [7:0]                        base_char,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic [1:0]                             kind,
  output logic [rsgm_pkg::VALUE_W-1:0]           value,
  output logic                                   last_of_run,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rsgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rsgm_pkg::SITE_W-1:0]       cfg_data
);

  logic [rsgm_pkg::SITE_W-1:0]     site_chars;
  logic [rsgm_pkg::SITE_LEN_W-1:0] site_length;
  rsgm_pkg::push_t                 push;
  rsgm_pkg::queue_stat_t           stat;
  logic                            pop;
  logic                            accept;

  assign cfg_ready  = 1'b1;
  assign item_ready = !stat.full;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      site_chars  <= rsgm_pkg::SITE_RESET;
      site_length <= rsgm_pkg::SITE_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsgm_pkg::CFG_SITE_CHARS:  site_chars  <= cfg_data;
        rsgm_pkg::CFG_SITE_LENGTH: site_length <= cfg_data[rsgm_pkg::SITE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  rsgm_front #(
    .MAX_SITE  (MAX_SITE),
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .base_char   (base_char),
    .site_chars  (site_chars),
    .site_length (site_length),
    .push_out    (push)
  );

  rsgm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (push),
    .pop     (pop),
    .stat    (stat)
  );

  rsgm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .stat         (stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .value        (value),
    .last_of_run  (last_of_run)
  );

endmodule
`default_nettype wire
